/* design/tsrr_pkg.sv */
// ----------------------------------------------------------------------------
// tsrr_pkg
// Shared types, constants and size tables of the tiled sprite row renderer.
// ----------------------------------------------------------------------------
package tsrr_pkg;

  localparam int CHAR_STORE_BYTES = 131072;  // power of two, 4096 .. 1048576
  localparam int MAX_SPRITE_SIDE  = 64;      // 8 .. 64
  localparam int CHAR_ADDR_W      = $clog2(CHAR_STORE_BYTES);
  localparam int SIDE_ROUNDED     = (MAX_SPRITE_SIDE / 8) * 8;
  localparam int SIDE_LIMIT       = (SIDE_ROUNDED < 8) ? 8 : SIDE_ROUNDED;

  localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    REQ_CHAR_WR = 2'd0,
    REQ_PAL_WR  = 2'd1,
    REQ_RENDER  = 2'd2,
    REQ_NONE    = 2'd3
  } req_code_t;

  typedef enum logic [2:0] {
    CFG_SIZE_CODE  = 3'd0,
    CFG_EIGHT_BIT  = 3'd1,
    CFG_START_TILE = 3'd2,
    CFG_MIRROR_H   = 3'd3,
    CFG_MIRROR_V   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [16:0] store_addr;
    logic [7:0]  store_byte;
    logic [7:0]  color_index;
    logic [23:0] color_rgb;
    logic [5:0]  row_number;
  } req_t;

  typedef struct packed {
    logic [5:0] column;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic [2:0]  size_code;
    logic        eight_bit_mode;
    logic [15:0] start_tile;
    logic        mirror_h;
    logic        mirror_v;
  } cfg_t;

  // travels with each character store read
  typedef struct packed {
    logic [5:0] col;
    logic       last;
    logic       hi_nib;
  } pix_tag_t;

  function automatic logic [6:0] clamp_side(logic [6:0] s);
    return (s > 7'(SIDE_LIMIT)) ? 7'(SIDE_LIMIT) : s;
  endfunction

  function automatic logic [6:0] side_w(logic [2:0] code);
    logic [6:0] s;
    case (code)
      3'd0:    s = 7'd8;
      3'd1:    s = 7'd16;
      3'd2:    s = 7'd32;
      3'd3:    s = 7'd64;
      3'd4:    s = 7'd16;
      3'd5:    s = 7'd32;
      3'd6:    s = 7'd32;
      default: s = 7'd8;
    endcase
    return clamp_side(s);
  endfunction

  function automatic logic [6:0] side_h(logic [2:0] code);
    logic [6:0] s;
    case (code)
      3'd0:    s = 7'd8;
      3'd1:    s = 7'd16;
      3'd2:    s = 7'd32;
      3'd3:    s = 7'd64;
      3'd4:    s = 7'd8;
      3'd5:    s = 7'd8;
      3'd6:    s = 7'd16;
      default: s = 7'd8;
    endcase
    return clamp_side(s);
  endfunction

endpackage

/* design/tiled_sprite_row_renderer.sv */
// ----------------------------------------------------------------------------
// tiled_sprite_row_renderer
// Renders one row of a tiled 4/8 bpp sprite to RGBA pixels.
// ----------------------------------------------------------------------------
// Request channel (in_valid/in_ready/in_data): character byte writes and
// palette writes go straight to the store and the palette. A render request
// produces the pixels of the named row on the out channel, column 0 first,
// last_pixel on the final one; a row at or beyond the sprite height, or an
// unknown request, produces nothing.
// A render request keeps in_ready low until every read of the row has been
// issued: a row of W pixels (8..64) gets one character store read per cycle
// while the queue has room, and each pixel goes through a registered store
// read and a registered palette read. Results wait in a 4-entry output queue;
// the sequencer only issues a read when the queue has room for it, so a
// stalled receiver just pauses the row. Configuration writes (cfg_valid/
// cfg_ready, always ready) take effect the next cycle; the user must make
// them only while the block is idle, as the block itself does not enforce
// it. Reset clears the configuration, control state and queue. Store and
// palette contents are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module tiled_sprite_row_renderer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsrr_pkg::req_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tsrr_pkg::pix_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  tsrr_pkg::cfg_t cfg;

  logic in_xfer;
  logic char_we;
  logic pal_we;
  logic start;
  logic seq_busy;
  logic seq_issue;
  logic advance;
  logic [tsrr_pkg::CHAR_ADDR_W-1:0] seq_addr;
  tsrr_pkg::pix_tag_t seq_tag;

  logic [7:0]  char_q;
  logic [23:0] pal_q;
  logic [7:0]  idx;
  logic [QPTR_W:0] in_flight;

  logic               s1_valid;
  tsrr_pkg::pix_tag_t s1_tag;
  logic               s2_valid;
  tsrr_pkg::pix_tag_t s2_tag;
  logic               s2_opaque;
  tsrr_pkg::pix_t     pix;

  tsrr_pkg::pix_t  q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (tsrr_pkg::cfg_reg_t'(cfg_index))
        tsrr_pkg::CFG_SIZE_CODE:  cfg.size_code      <= cfg_data[2:0];
        tsrr_pkg::CFG_EIGHT_BIT:  cfg.eight_bit_mode <= cfg_data[0];
        tsrr_pkg::CFG_START_TILE: cfg.start_tile     <= cfg_data;
        tsrr_pkg::CFG_MIRROR_H:   cfg.mirror_h       <= cfg_data[0];
        tsrr_pkg::CFG_MIRROR_V:   cfg.mirror_v       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request decode
  assign in_ready = !seq_busy;
  assign in_xfer  = in_valid && in_ready;
  assign char_we  = in_xfer && (in_data.req_type == tsrr_pkg::REQ_CHAR_WR);
  assign pal_we   = in_xfer && (in_data.req_type == tsrr_pkg::REQ_PAL_WR);
  assign start    = in_xfer && (in_data.req_type == tsrr_pkg::REQ_RENDER) &&
                    ({1'b0, in_data.row_number} < tsrr_pkg::side_h(cfg.size_code));

  tsrr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .row_number (in_data.row_number),
    .advance    (advance),
    .busy       (seq_busy),
    .issue      (seq_issue),
    .rd_addr    (seq_addr),
    .tag        (seq_tag)
  );

  tsrr_ram #(
    .ADDR_W (tsrr_pkg::CHAR_ADDR_W),
    .DATA_W (8)
  ) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (tsrr_pkg::CHAR_ADDR_W'(in_data.store_addr)),
    .wdata (in_data.store_byte),
    .raddr (seq_addr),
    .rdata (char_q)
  );

  // stage 1: character byte -> palette index
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= seq_issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag <= seq_tag;
  end

  always_comb begin
    if (cfg.eight_bit_mode) begin
      idx = char_q;
    end else if (s1_tag.hi_nib) begin
      idx = {4'd0, char_q[7:4]};
    end else begin
      idx = char_q & tsrr_pkg::NIBBLE_MASK;
    end
  end

  tsrr_ram #(
    .ADDR_W (8),
    .DATA_W (24)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_data.color_index),
    .wdata (in_data.color_rgb),
    .raddr (idx),
    .rdata (pal_q)
  );

  // stage 2: palette color -> pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_tag    <= s1_tag;
    s2_opaque <= (idx != 8'd0);
  end

  assign pix.column     = s2_tag.col;
  assign pix.red        = s2_opaque ? pal_q[23:16] : 8'd0;
  assign pix.green      = s2_opaque ? pal_q[15:8]  : 8'd0;
  assign pix.blue       = s2_opaque ? pal_q[7:0]   : 8'd0;
  assign pix.alpha      = s2_opaque ? tsrr_pkg::ALPHA_OPAQUE : 8'd0;
  assign pix.last_pixel = s2_tag.last;

  // output queue; reads only go out when a slot is reserved for them
  assign in_flight = (QPTR_W+1)'(s1_valid) + (QPTR_W+1)'(s2_valid);
  assign advance   = (count + in_flight) < (QPTR_W+1)'(QDEPTH);
  assign out_valid = (count != '0);
  assign out_data  = q_mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      q_mem[wr_ptr] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (s2_valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !s2_valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/tsrr_ram.sv */
// ----------------------------------------------------------------------------
// tsrr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsrr_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];  // old data on a same-cycle write
  end

endmodule

/* design/tsrr_seq.sv */
// ----------------------------------------------------------------------------
// tsrr_seq
// Row sequencer: walks the columns of one sprite row and issues one
// character store read address per pixel.
// ----------------------------------------------------------------------------
module tsrr_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  tsrr_pkg::cfg_t                      cfg,
  input  logic                                start,
  input  logic [5:0]                          row_number,
  input  logic                                advance,
  output logic                                busy,
  output logic                                issue,
  output logic [tsrr_pkg::CHAR_ADDR_W-1:0]    rd_addr,
  output tsrr_pkg::pix_tag_t                  tag
);

  logic [6:0]  w;
  logic [6:0]  h;
  logic [5:0]  wm1;
  logic [3:0]  tw;
  logic [5:0]  mrow;
  logic [15:0] base_next;
  logic [5:0]  mcol;
  logic [15:0] tile;
  logic [21:0] addr8;
  logic [20:0] addr4;

  logic [15:0] base;
  logic [2:0]  line;
  logic [5:0]  col;

  assign w    = tsrr_pkg::side_w(cfg.size_code);
  assign h    = tsrr_pkg::side_h(cfg.size_code);
  assign wm1  = 6'(w - 7'd1);
  assign tw   = w[6:3];

  // with sides a multiple of 8, mirroring the row/column mirrors tile and pixel
  assign mrow      = cfg.mirror_v ? 6'(h - 7'd1) - row_number : row_number;
  assign base_next = {1'b0, cfg.start_tile[15:1]} + 16'(mrow[5:3]) * 16'(tw);

  assign mcol  = cfg.mirror_h ? wm1 - col : col;
  assign tile  = base + 16'(mcol[5:3]);
  assign addr8 = {tile, line, mcol[2:0]};
  assign addr4 = {tile, line, mcol[2:1]};

  assign issue   = busy && advance;
  assign rd_addr = cfg.eight_bit_mode ? tsrr_pkg::CHAR_ADDR_W'(addr8)
                                      : tsrr_pkg::CHAR_ADDR_W'(addr4);
  assign tag.col    = col;
  assign tag.last   = (col == wm1);
  assign tag.hi_nib = mcol[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      col  <= 6'd0;
    end else if (start) begin
      busy <= 1'b1;
      col  <= 6'd0;
    end else if (issue) begin
      col <= col + 6'd1;
      if (col == wm1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base <= base_next;
      line <= mrow[2:0];
    end
  end

endmodule

/* design/tsrr_checker.sv */
// ----------------------------------------------------------------------------
// tsrr_checker
// Port-level checks of the sprite row renderer, bound to the top level.
// ----------------------------------------------------------------------------
module tsrr_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input tsrr_pkg::pix_t out_data,
  input logic           cfg_ready
);

  // a stalled pixel stays offered unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pixel dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("pixel offered right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

  // rows are multiples of 8 pixels wide
  a_last_col: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_pixel |-> out_data.column[2:0] == 3'd7)
    else $error("last pixel not at end of a tile");

  a_col_63_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.column == 6'd63 |-> out_data.last_pixel)
    else $error("column 63 without last mark");

endmodule

bind tiled_sprite_row_renderer tsrr_checker u_tsrr_checker (.*);
